[design/ppg_pkg.sv]
// plasma pixel generator package: widths, phase constants, register indexes
// and the sine table built at elaboration; no dependencies
package ppg_pkg;

	localparam int COORD_BITS      = 12;
	localparam int SINE_TABLE_BITS = 10;
	localparam int TAB_N           = 1 << SINE_TABLE_BITS;

	localparam int DIM_BITS  = 13;
	localparam int DIV_BITS  = COORD_BITS + 16;
	localparam int ARG_BITS  = DIV_BITS + 18;
	localparam int ARG_LO    = 24;
	localparam int ARG_HI    = ARG_BITS - ARG_LO;
	localparam int LK_BITS   = 21;
	localparam int IDX_BITS  = 2;

	localparam logic [31:0] TIME_STEP   = 32'd11392755;
	localparam logic [31:0] TIME13_STEP = 32'd14810581;
	localparam logic [31:0] INV_PI_32   = 32'd1367130551;
	localparam logic [31:0] INV_PI_33   = 32'd2734261103;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [IDX_BITS-1:0] REG_WIDTH  = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_HEIGHT = IDX_BITS'(1);

	typedef logic signed [15:0] sine_tab_t [TAB_N];

	// taylor series of sin(f*pi/2), f in q30, result q15 in 0..32767
	function automatic logic signed [15:0] quarter_sine(input logic [63:0] f);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		longint      r;
		x = (f * HALF_PI_Q30) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			r = 0;
		else
			r = (sum + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		return 16'(r);
	endfunction

	function automatic sine_tab_t build_tab();
		sine_tab_t         t;
		int                quad;
		logic [63:0]       f;
		logic signed [15:0] v;
		for (int i = 0; i < TAB_N; i++) begin
			quad = i >> (SINE_TABLE_BITS - 2);
			f = 64'(i & ((TAB_N >> 2) - 1)) << (30 - (SINE_TABLE_BITS - 2));
			if (quad % 2 == 1)
				f = (64'd1 << 30) - f;
			v = quarter_sine(f);
			t[i] = (quad >= 2) ? -v : v;
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_tab();

endpackage

[design/plasma_pixel_generator.sv]
// plasma pixel generator top: divider pipeline, phase math, sine units, colors
// depends on ppg_pkg and ppg_sine
//
// channel | signals                                   | request
// pixel   | pix_valid pix_stall pixel_x pixel_y frame | one coordinate and frame
// color   | rgb_valid rgb_stall red green blue        | one color
// config  | cfg_valid cfg_ready cfg_index cfg_data    | one register write
//
// one pixel enters per cycle while pix_stall is low; the COORD_BITS+16 divider stages
// are bit-per-stage restoring dividers, followed by the phase math and three sine units in series
// a stalled color freezes the whole pipeline, so pix_stall follows rgb_stall
// reset clears valid bits and sets both dimensions to 256; cfg is always ready
module plasma_pixel_generator import ppg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [11:0]           pixel_x,
	input  logic [11:0]           pixel_y,
	input  logic [31:0]           frame_number,
	output logic                  rgb_valid,
	input  logic                  rgb_stall,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_BITS-1:0]   cfg_index,
	input  logic [DIM_BITS-1:0]   cfg_data
);

	localparam int NPOST = 18;
	localparam logic [4:0] CH_K [3] = '{5'd6, 5'd7, 5'd10};

	logic                adv;
	logic [DIM_BITS-1:0] wdiv_q;
	logic [DIM_BITS-1:0] hdiv_q;
	logic [DIM_BITS-1:0] cfg_div;

	logic                dv_s   [0:DIV_BITS];
	logic [DIM_BITS-1:0] xrem_s [0:DIV_BITS];
	logic [DIM_BITS-1:0] yrem_s [0:DIV_BITS];
	logic [DIV_BITS-1:0] xq_s   [0:DIV_BITS];
	logic [DIV_BITS-1:0] yq_s   [0:DIV_BITS];
	logic [DIV_BITS-1:0] xnum_s [0:DIV_BITS];
	logic [DIV_BITS-1:0] ynum_s [0:DIV_BITS];
	logic [31:0]         tph_s  [0:DIV_BITS];
	logic [31:0]         t13_s  [0:DIV_BITS];

	logic                vld_s [1:NPOST];

	logic [DIV_BITS+31:0]       pyk;
	logic [31:0]                ph4_s1;
	logic [31:0]                tph_s1;
	logic [31:0]                t13_s1;
	logic [31:0]                phb_s2;
	logic [31:0]                tph_s2;
	logic [31:0]                t13_s2;
	logic [DIV_BITS-1:0]        px_s1;
	logic [DIV_BITS-1:0]        px_s2;
	logic [DIV_BITS-1:0]        px_s3;
	logic [DIV_BITS-1:0]        px_s4;
	logic [DIV_BITS-1:0]        px_s5;
	logic signed [15:0]         sa;
	logic signed [15:0]         st;
	logic signed [15:0]         sb;
	logic signed [DIV_BITS+16:0] m1_s6;
	logic signed [31:0]         m2_s6;
	logic signed [ARG_BITS-1:0] arg_s7;
	logic signed [ARG_HI+32:0]  hic_s8;
	logic [ARG_LO+31:0]         loc_s8;
	logic [63:0]                lsum;
	logic [31:0]                lph_s9;
	logic signed [15:0]         lvl;

	logic signed [LK_BITS-1:0]  lk_s13 [3];
	logic [31:0]                cph_s14 [3];
	logic signed [15:0]         cs [3];
	logic [7:0]                 col_s18 [3];

	assign adv       = ~(vld_s[NPOST] & rgb_stall);
	assign pix_stall = ~adv;
	assign cfg_ready = 1'b1;
	assign rgb_valid = vld_s[NPOST];
	assign red       = col_s18[0];
	assign green     = col_s18[1];
	assign blue      = col_s18[2];
	assign cfg_div   = (cfg_data == '0) ? DIM_BITS'(1) : cfg_data;

	// configuration, a zero dimension divides as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdiv_q <= DIM_BITS'(256);
			hdiv_q <= DIM_BITS'(256);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  wdiv_q <= cfg_div;
				REG_HEIGHT: hdiv_q <= cfg_div;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_BITS; i++)
				dv_s[i] <= 1'b0;
			for (int i = 1; i <= NPOST; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= pix_valid;
			for (int i = 1; i <= DIV_BITS; i++)
				dv_s[i] <= dv_s[i-1];
			vld_s[1] <= dv_s[DIV_BITS];
			for (int i = 2; i <= NPOST; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xrem_s[0] <= '0;
			yrem_s[0] <= '0;
			xq_s[0]   <= '0;
			yq_s[0]   <= '0;
			xnum_s[0] <= {COORD_BITS'(pixel_x), 16'd0};
			ynum_s[0] <= {COORD_BITS'(pixel_y), 16'd0};
			tph_s[0]  <= frame_number * TIME_STEP;
			t13_s[0]  <= frame_number * TIME13_STEP;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [DIM_BITS:0] xsh;
		logic [DIM_BITS:0] ysh;
		logic              xge;
		logic              yge;
		assign xsh = {xrem_s[k], xnum_s[k][DIV_BITS-1]};
		assign ysh = {yrem_s[k], ynum_s[k][DIV_BITS-1]};
		assign xge = xsh >= {1'b0, wdiv_q};
		assign yge = ysh >= {1'b0, hdiv_q};
		always_ff @(posedge clk) begin
			if (adv) begin
				xrem_s[k+1] <= xge ? DIM_BITS'(xsh - {1'b0, wdiv_q}) : xsh[DIM_BITS-1:0];
				yrem_s[k+1] <= yge ? DIM_BITS'(ysh - {1'b0, hdiv_q}) : ysh[DIM_BITS-1:0];
				xq_s[k+1]   <= {xq_s[k][DIV_BITS-2:0], xge};
				yq_s[k+1]   <= {yq_s[k][DIV_BITS-2:0], yge};
				xnum_s[k+1] <= xnum_s[k] << 1;
				ynum_s[k+1] <= ynum_s[k] << 1;
				tph_s[k+1]  <= tph_s[k];
				t13_s[k+1]  <= t13_s[k];
			end
		end
	end

	assign pyk  = (DIV_BITS+32)'(yq_s[DIV_BITS]) * (DIV_BITS+32)'(INV_PI_33);
	assign lsum = (64'(hic_s8) << ARG_LO) + 64'(loc_s8);

	always_ff @(posedge clk) begin
		if (adv) begin
			ph4_s1 <= pyk[47:16];
			tph_s1 <= tph_s[DIV_BITS];
			t13_s1 <= t13_s[DIV_BITS];
			px_s1  <= xq_s[DIV_BITS];
			phb_s2 <= ph4_s1 + tph_s1;
			tph_s2 <= tph_s1;
			t13_s2 <= t13_s1;
			px_s2  <= px_s1;
			px_s3  <= px_s2;
			px_s4  <= px_s3;
			px_s5  <= px_s4;
			m1_s6  <= $signed({1'b0, px_s5}) * sa;
			m2_s6  <= sb * st;
			arg_s7 <= ARG_BITS'(m1_s6) + (ARG_BITS'(m2_s6) <<< 1);
			hic_s8 <= $signed(arg_s7[ARG_BITS-1 -: ARG_HI]) * $signed({1'b0, INV_PI_32});
			loc_s8 <= (ARG_LO+32)'(arg_s7[ARG_LO-1:0]) * (ARG_LO+32)'(INV_PI_32);
			lph_s9 <= lsum[63:32];
		end
	end

	ppg_sine u_sa (.clk(clk), .en(adv), .phase(t13_s2), .sine(sa));
	ppg_sine u_st (.clk(clk), .en(adv), .phase(tph_s2), .sine(st));
	ppg_sine u_sb (.clk(clk), .en(adv), .phase(phb_s2), .sine(sb));
	ppg_sine u_lv (.clk(clk), .en(adv), .phase(lph_s9), .sine(lvl));

	for (genvar j = 0; j < 3; j++) begin : g_lane
		logic signed [LK_BITS+32:0] cp;
		logic [22:0]                scaled;
		assign cp     = lk_s13[j] * $signed({1'b0, INV_PI_32});
		assign scaled = 23'({~cs[j][15], cs[j][14:0]}) * 23'd127;
		always_ff @(posedge clk) begin
			if (adv) begin
				lk_s13[j]  <= LK_BITS'(lvl) * LK_BITS'($signed({1'b0, CH_K[j]}));
				cph_s14[j] <= cp[47:16];
				col_s18[j] <= scaled[22:15];
			end
		end
		ppg_sine u_ch (.clk(clk), .en(adv), .phase(cph_s14[j]), .sine(cs[j]));
	end

endmodule

[design/ppg_sine.sv]
// three-stage sine unit: table lookup, interpolation products, rounding
// depends on ppg_pkg for the table and its size
module ppg_sine import ppg_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [15:0] sine
);

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS-1:0] idx1;
	logic [15:0]                tab0;
	logic [15:0]                tab1;
	logic [15:0]                b0_s1;
	logic [15:0]                b1_s1;
	logic [15:0]                fr_s1;
	logic [32:0]                p0_s2;
	logic [31:0]                p1_s2;
	logic [33:0]                sum;

	assign idx  = phase[31 -: SINE_TABLE_BITS];
	assign idx1 = idx + SINE_TABLE_BITS'(1);
	assign tab0 = SINE_TAB[idx];
	assign tab1 = SINE_TAB[idx1];
	assign sum  = 34'(p0_s2) + 34'(p1_s2) + 34'd32768;

	// adding 32768 to a q1.15 value flips its top bit
	always_ff @(posedge clk) begin
		if (en) begin
			b0_s1 <= {~tab0[15], tab0[14:0]};
			b1_s1 <= {~tab1[15], tab1[14:0]};
			fr_s1 <= phase[31-SINE_TABLE_BITS -: 16];
			p0_s2 <= 33'(b0_s1) * (33'h10000 - 33'(fr_s1));
			p1_s2 <= 32'(b1_s1) * 32'(fr_s1);
			sine  <= {~sum[31], sum[30:16]};
		end
	end

endmodule

[design/ppg_checker.sv]
// port-level checks for the plasma pixel generator, bound to the top level
// depends only on the top level's handshake and color ports
module ppg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pix_stall,
	input logic                rgb_valid,
	input logic                rgb_stall,
	input logic [7:0]          red,
	input logic [7:0]          green,
	input logic [7:0]          blue
);

	// the pipeline only holds pixels back while a color is held back
	a_stall_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall == (rgb_valid && rgb_stall))
		else $error("pixel stall does not follow color stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> (red <= 8'd254 && green <= 8'd254 && blue <= 8'd254))
		else $error("color channel out of range");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid)
		else $error("stalled color dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("stalled color changed");

endmodule

bind plasma_pixel_generator ppg_checker u_ppg_checker (.*);
